// ===== design/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WAVP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define WAVP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/wavp_pkg.sv =====
`timescale 1ns / 1ps

package wavp_pkg;

    localparam logic [1:0] K_HEADER  = 2'd0;
    localparam logic [1:0] K_PAYLOAD = 2'd1;
    localparam logic [1:0] K_ERROR   = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_WAVE  = 3'd1;
    localparam logic [2:0] ST_NOT_FMT   = 3'd2;
    localparam logic [2:0] ST_CHANNELS  = 3'd3;
    localparam logic [2:0] ST_DEPTH     = 3'd4;
    localparam logic [2:0] ST_NO_DATA   = 3'd5;
    localparam logic [2:0] ST_SIZE_RATE = 3'd6;
    localparam logic [2:0] ST_TRUNC     = 3'd7;

    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    localparam logic [31:0] POS_WAVE_END = 32'd11;
    localparam logic [31:0] POS_FMT_END  = 32'd15;
    localparam logic [31:0] SEARCH_START = 32'd36;
    localparam logic [31:0] POS_CHANNELS = 32'd22;
    localparam logic [31:0] POS_RATE     = 32'd24;
    localparam logic [31:0] POS_BITS     = 32'd34;
    localparam int          BITS_SHIFT   = 3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  status;
        logic [30:0] sample_rate;
        logic [1:0]  byte_depth;
        logic [1:0]  channel_count;
        logic [30:0] data_size;
        logic [7:0]  payload;
        logic        last_of_data;
    } t_result;

    function automatic logic [15:0] swap16(input logic [15:0] w);
        return {w[7:0], w[15:8]};
    endfunction

    function automatic logic [31:0] swap32(input logic [31:0] w);
        return {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

    function automatic logic is_positive(input logic [31:0] v);
        return (v != 32'd0) && !v[31];
    endfunction

endpackage

// ===== design/wavp_front.sv =====
`timescale 1ns / 1ps

module wavp_front import wavp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_file,
    output logic       o_stall,
    input  logic       i_full,
    output logic       o_push,
    output t_result    o_result
);

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_SEARCH  = 3'd1,
        PH_SIZE    = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_DRAIN   = 3'd4
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [31:0] r_pos, n_pos;
    logic [31:0] r_window, n_window;
    logic [31:0] r_rate, n_rate;
    logic [1:0]  r_channels, n_channels;
    logic [1:0]  r_depth, n_depth;
    logic [30:0] r_remaining, n_remaining;

    logic        accept;
    logic [31:0] w;
    logic [15:0] ch;
    logic [12:0] dep;
    logic [31:0] size;
    logic [2:0]  err;
    logic        emit;
    t_result     res;

    assign accept  = i_valid && !i_full;
    assign o_stall = i_full;
    assign w       = {r_window[23:0], i_in_byte};
    assign ch      = swap16(w[15:0]);
    assign dep     = 13'(swap16(w[15:0]) >> BITS_SHIFT);
    assign size    = swap32(w);

    always_comb begin
        n_phase     = r_phase;
        n_pos       = r_pos;
        n_window    = r_window;
        n_rate      = r_rate;
        n_channels  = r_channels;
        n_depth     = r_depth;
        n_remaining = r_remaining;
        err         = ST_OK;
        emit        = 1'b0;
        res         = '0;
        if (accept) begin
            n_window = w;
            n_pos    = (r_pos == '1) ? r_pos : r_pos + 32'd1;
            unique case (r_phase)
                PH_HEADER: begin
                    if (r_pos == POS_WAVE_END && w != TAG_WAVE) begin
                        err = ST_NOT_WAVE;
                    end else if (r_pos == POS_FMT_END && w != TAG_FMT) begin
                        err = ST_NOT_FMT;
                    end else if (r_pos == POS_CHANNELS + 32'd1) begin
                        if (ch != 16'd1 && ch != 16'd2) begin
                            err = ST_CHANNELS;
                        end else begin
                            n_channels = ch[1:0];
                        end
                    end else if (r_pos == POS_RATE + 32'd3) begin
                        n_rate = size;
                    end else if (r_pos == POS_BITS + 32'd1) begin
                        if (dep != 13'd1 && dep != 13'd2) begin
                            err = ST_DEPTH;
                        end else begin
                            n_depth = dep[1:0];
                        end
                    end
                    if (err == ST_OK && r_pos == SEARCH_START + 32'd2) begin
                        n_phase = PH_SEARCH;
                    end
                    if (err == ST_OK && i_end_of_file) begin
                        err = ST_TRUNC;
                    end
                end
                PH_SEARCH: begin
                    if (w == TAG_DATA) begin
                        n_phase     = PH_SIZE;
                        n_remaining = '0;
                        if (i_end_of_file) begin
                            err = ST_TRUNC;
                        end
                    end else if (i_end_of_file) begin
                        err = ST_NO_DATA;
                    end
                end
                PH_SIZE: begin
                    if (r_remaining >= 31'd3) begin
                        if (!is_positive(size) || !is_positive(r_rate)) begin
                            err = ST_SIZE_RATE;
                        end else if (i_end_of_file) begin
                            err = ST_TRUNC;
                        end else begin
                            emit              = 1'b1;
                            res.kind          = K_HEADER;
                            res.status        = ST_OK;
                            res.sample_rate   = r_rate[30:0];
                            res.byte_depth    = r_depth;
                            res.channel_count = r_channels;
                            res.data_size     = size[30:0];
                            n_remaining       = size[30:0];
                            n_phase           = PH_PAYLOAD;
                        end
                    end else begin
                        n_remaining = r_remaining + 31'd1;
                        if (i_end_of_file) begin
                            err = ST_TRUNC;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    if (r_remaining != '0) begin
                        emit        = 1'b1;
                        res.kind    = K_PAYLOAD;
                        res.payload = i_in_byte;
                        n_remaining = r_remaining - 31'd1;
                        if (r_remaining == 31'd1) begin
                            res.last_of_data = 1'b1;
                            n_phase          = PH_DRAIN;
                        end else if (i_end_of_file) begin
                            res.status       = ST_TRUNC;
                            res.last_of_data = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
            if (err != ST_OK) begin
                emit             = 1'b1;
                res              = '0;
                res.kind         = K_ERROR;
                res.status       = err;
                res.last_of_data = 1'b1;
                n_phase          = PH_DRAIN;
            end
            if (i_end_of_file) begin
                n_phase     = PH_HEADER;
                n_pos       = '0;
                n_window    = '0;
                n_rate      = '0;
                n_channels  = '0;
                n_depth     = '0;
                n_remaining = '0;
            end
        end
    end

    assign o_push   = emit;
    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_pos       <= '0;
            r_window    <= '0;
            r_rate      <= '0;
            r_channels  <= '0;
            r_depth     <= '0;
            r_remaining <= '0;
        end else begin
            r_phase     <= n_phase;
            r_pos       <= n_pos;
            r_window    <= n_window;
            r_rate      <= n_rate;
            r_channels  <= n_channels;
            r_depth     <= n_depth;
            r_remaining <= n_remaining;
        end
    end

endmodule

// ===== design/wavp_fifo.sv =====
`timescale 1ns / 1ps

module wavp_fifo import wavp_pkg::*; #(
    parameter int P_DEPTH = 4
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_wdata,
    output logic    o_full,
    output logic    o_valid,
    input  logic    i_pop,
    output t_result o_rdata
);

    localparam int AW = $clog2(P_DEPTH);
    localparam int CW = $clog2(P_DEPTH + 1);

    t_result         mem [P_DEPTH];
    logic [AW-1:0]   r_wr, n_wr;
    logic [AW-1:0]   r_rd, n_rd;
    logic [CW-1:0]   r_count, n_count;

    assign o_full  = (r_count == CW'(P_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_rdata = mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == AW'(P_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == AW'(P_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        unique case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            mem[r_wr] <= i_wdata;
        end
    end

endmodule

// ===== design/wavp_back.sv =====
`timescale 1ns / 1ps

module wavp_back import wavp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fifo_valid,
    input  t_result i_fifo_data,
    output logic    o_pop,
    input  logic    i_stall,
    output logic    o_valid,
    output t_result o_data
);

    logic    r_valid;
    t_result r_data;
    logic    load;

    assign load    = !r_valid || !i_stall;
    assign o_pop   = i_fifo_valid && load;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_fifo_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= i_fifo_data;
        end
    end

endmodule

// ===== design/wav_header_parser.sv =====
`timescale 1ns / 1ps

// WAV header parser: takes one file byte per beat and, after checking the WAVE/fmt
// header and finding the data chunk, gives one header summary, then the payload bytes,
// or one error report on the byte that decides it; i_end_of_file on a byte returns the
// parser to the start of a new file. It accepts one byte every cycle while o_stall is low;
// an accepted byte's result is written into a queue of P_QUEUE_DEPTH entries and waits
// there until the output register takes it; o_stall rises only when that queue is full.
module wav_header_parser import wavp_pkg::*; #(
    parameter int P_QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_end_of_file,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [2:0]  o_status,
    output logic [30:0] o_sample_rate,
    output logic [1:0]  o_byte_depth,
    output logic [1:0]  o_channel_count,
    output logic [30:0] o_data_size,
    output logic [7:0]  o_payload,
    output logic        o_last_of_data
);

    logic    push, full, fifo_valid, pop;
    t_result push_data, fifo_data, out_data;

    wavp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_in_byte     (i_in_byte),
        .i_end_of_file (i_end_of_file),
        .o_stall       (o_stall),
        .i_full        (full),
        .o_push        (push),
        .o_result      (push_data)
    );

    wavp_fifo #(.P_DEPTH(P_QUEUE_DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (push_data),
        .o_full  (full),
        .o_valid (fifo_valid),
        .i_pop   (pop),
        .o_rdata (fifo_data)
    );

    wavp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fifo_valid (fifo_valid),
        .i_fifo_data  (fifo_data),
        .o_pop        (pop),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_data       (out_data)
    );

    assign o_kind          = out_data.kind;
    assign o_status        = out_data.status;
    assign o_sample_rate   = out_data.sample_rate;
    assign o_byte_depth    = out_data.byte_depth;
    assign o_channel_count = out_data.channel_count;
    assign o_data_size     = out_data.data_size;
    assign o_payload       = out_data.payload;
    assign o_last_of_data  = out_data.last_of_data;

endmodule

// ===== design/wavp_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wavp_checker import wavp_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [1:0]  o_kind,
    input logic [2:0]  o_status,
    input logic [30:0] o_sample_rate,
    input logic [1:0]  o_byte_depth,
    input logic [1:0]  o_channel_count,
    input logic [30:0] o_data_size,
    input logic [7:0]  o_payload,
    input logic        o_last_of_data
);

    `WAVP_ASSERT_IMP(a_header_ok, i_clk, i_rst_n, o_valid && o_kind == K_HEADER, o_status == ST_OK && !o_last_of_data && o_data_size != '0 && o_sample_rate != '0 && (o_byte_depth == 2'd1 || o_byte_depth == 2'd2) && (o_channel_count == 2'd1 || o_channel_count == 2'd2), "bad header summary")

    `WAVP_ASSERT_IMP(a_error_last, i_clk, i_rst_n, o_valid && o_kind == K_ERROR, o_last_of_data && o_status != ST_OK && o_payload == '0, "error report malformed")

    `WAVP_ASSERT_IMP(a_kind_code, i_clk, i_rst_n, o_valid, o_kind == K_HEADER || o_kind == K_PAYLOAD || o_kind == K_ERROR, "unused kind code")

    `WAVP_ASSERT_IMP(a_trunc_last, i_clk, i_rst_n, o_valid && o_kind == K_PAYLOAD && o_status != ST_OK, o_status == ST_TRUNC && o_last_of_data, "payload status without end")

    `WAVP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_kind) && $stable(o_payload), "stalled beat changed")

endmodule

bind wav_header_parser wavp_checker u_checker (.*);
